>>> design/chte_pkg.sv
// Package for the chained hash table engine: action and status codes,
// controller state type. Used by the engine unit; no dependencies.
package chte_pkg;
	typedef enum logic [1:0] {
		ACT_FIND   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_ERASE  = 2'd2,
		ACT_SPARE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_SPARE    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_HEAD_RD,
		S_HEAD_WAIT,
		S_WALK_RD,
		S_WALK_CHK,
		S_FREE_RD,
		S_FREE_WAIT,
		S_UPDATE,
		S_OUT
	} state_t;
endpackage

>>> design/chte_mod.sv
// Sequential remainder unit: 64-bit key modulo a 12-bit divisor, one bit a cycle.
// Depends on nothing but its ports.
module chte_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [11:0] divisor,
	output logic        done,
	output logic [11:0] remainder
);
	logic [63:0] shift_q;
	logic [12:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [12:0] trial;

	always_comb begin
		trial = {rem_q[11:0], shift_q[63]};
		if (trial >= {1'b0, divisor}) begin
			trial = trial - {1'b0, divisor};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[62:0], 1'b0};
			rem_q   <= trial;
		end
	end

	assign remainder = rem_q[11:0];
endmodule

>>> design/chained_hash_table_engine_unit.sv
// Chained hash table engine: 64-bit keys and values in a pool of ENTRIES
// entries, chained per bucket. Depends on chte_pkg and chte_mod.
//
// One transaction is handled at a time. The key first goes through the
// bit-serial key modulo, and the chain is then walked through the single-port
// entry memories, one entry after another; an insert of a new key also reads
// the free stack. The next transaction can be taken in the cycle after the
// result is accepted. After reset the bucket head memory is cleared, one
// bucket a cycle, before the first item is taken; configuration writes are
// taken throughout.
module chained_hash_table_engine_unit #(
	parameter int BUCKETS = 2048,
	parameter int ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] key,
	input  logic [63:0] value_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [63:0] value_out,
	output logic [1:0]  status,
	output logic [8:0]  entry_count
);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int EW = $clog2(ENTRIES);
	localparam int PW = EW + 1;          // entry pointer incl. null code
	localparam int CW = EW + 1;
	localparam logic [PW-1:0] NULLP = PW'(ENTRIES);

	chte_pkg::state_t state_q, state_d;

	logic [11:0] bcount_q;
	logic [11:0] active_b;
	always_comb begin
		active_b = bcount_q;
		if (active_b == 12'd0) active_b = 12'd1;
		if (32'(active_b) > BUCKETS) active_b = 12'(BUCKETS);
	end

	// memories
	logic [PW-1:0] head_mem [BUCKETS];
	logic [63:0]   key_mem  [ENTRIES];
	logic [63:0]   val_mem  [ENTRIES];
	logic [PW-1:0] link_mem [ENTRIES];
	logic [EW-1:0] free_mem [ENTRIES];

	logic [PW-1:0] head_rd_q, link_rd_q;
	logic [63:0]   key_rd_q, val_rd_q;
	logic [EW-1:0] free_rd_q;

	logic [1:0]    act_q;
	logic [63:0]   key_q, vin_q;
	logic [BW-1:0] bkt_q;
	logic [PW-1:0] cur_q, prev_q, hitlink_q;
	logic [CW-1:0] live_q;
	logic [CW-1:0] steps_q;
	logic [BW:0]   clr_q;
	logic          hit_q;
	logic [63:0]   hitval_q;
	logic [EW-1:0] hitidx_q;
	logic [EW-1:0] fresh_q;

	logic          mod_start, mod_done;
	logic [11:0]   mod_rem;

	chte_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(key_q),
		.divisor(active_b), .done(mod_done), .remainder(mod_rem)
	);

	logic accept, deliver, is_ins, is_era, full_now;
	assign accept   = in_valid && !in_stall;
	assign deliver  = out_valid && !out_stall;
	assign is_ins   = act_q == chte_pkg::ACT_INSERT;
	assign is_era   = act_q == chte_pkg::ACT_ERASE;
	assign full_now = live_q == CW'(ENTRIES);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			chte_pkg::S_CLEAR:     if (clr_q == (BW+1)'(BUCKETS - 1)) state_d = chte_pkg::S_IDLE;
			chte_pkg::S_IDLE:      if (accept) state_d = chte_pkg::S_MOD;
			chte_pkg::S_MOD:       if (mod_done) state_d = chte_pkg::S_HEAD_RD;
			chte_pkg::S_HEAD_RD:   state_d = chte_pkg::S_HEAD_WAIT;
			chte_pkg::S_HEAD_WAIT: state_d = chte_pkg::S_WALK_RD;
			chte_pkg::S_WALK_RD: begin
				if (cur_q >= NULLP || steps_q == CW'(ENTRIES) || hit_q)
					state_d = (is_ins && !hit_q && !full_now) ?
						chte_pkg::S_FREE_RD : chte_pkg::S_UPDATE;
				else
					state_d = chte_pkg::S_WALK_CHK;
			end
			chte_pkg::S_WALK_CHK:  state_d = chte_pkg::S_WALK_RD;
			chte_pkg::S_FREE_RD:   state_d = chte_pkg::S_FREE_WAIT;
			chte_pkg::S_FREE_WAIT: state_d = chte_pkg::S_UPDATE;
			chte_pkg::S_UPDATE:    state_d = chte_pkg::S_OUT;
			chte_pkg::S_OUT:       if (deliver) state_d = chte_pkg::S_IDLE;
			default:               state_d = chte_pkg::S_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		in_stall  = state_q != chte_pkg::S_IDLE;
		mod_start = state_q == chte_pkg::S_MOD && !mod_done && steps_q == '0
			&& clr_q[0];
		out_valid = state_q == chte_pkg::S_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= chte_pkg::S_CLEAR;
			bcount_q <= 12'(BUCKETS);
			live_q   <= '0;
			clr_q    <= '0;
			steps_q  <= '0;
			hit_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) bcount_q <= cfg_wdata;
			case (state_q)
				chte_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
				chte_pkg::S_IDLE: begin
					clr_q   <= (BW+1)'(1);
					steps_q <= '0;
					hit_q   <= 1'b0;
				end
				chte_pkg::S_MOD: clr_q <= '0;
				chte_pkg::S_WALK_CHK: begin
					steps_q <= steps_q + 1'b1;
					if (key_rd_q == key_q) hit_q <= 1'b1;
				end
				chte_pkg::S_UPDATE: begin
					if (is_ins && !hit_q && !full_now) live_q <= live_q + 1'b1;
					else if (is_era && hit_q) live_q <= live_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath and memory ports
	always_ff @(posedge clk) begin
		case (state_q)
			chte_pkg::S_CLEAR: head_mem[clr_q[BW-1:0]] <= NULLP;
			chte_pkg::S_IDLE: begin
				act_q <= action;
				key_q <= key;
				vin_q <= value_in;
			end
			chte_pkg::S_MOD: bkt_q <= mod_rem[BW-1:0];
			chte_pkg::S_HEAD_RD: head_rd_q <= head_mem[bkt_q];
			chte_pkg::S_HEAD_WAIT: begin
				cur_q  <= head_rd_q;
				prev_q <= NULLP;
			end
			chte_pkg::S_WALK_RD: begin
				if (cur_q < NULLP) begin
					key_rd_q  <= key_mem[cur_q[EW-1:0]];
					val_rd_q  <= val_mem[cur_q[EW-1:0]];
					link_rd_q <= link_mem[cur_q[EW-1:0]];
				end
			end
			chte_pkg::S_WALK_CHK: begin
				if (key_rd_q == key_q) begin
					hitidx_q  <= cur_q[EW-1:0];
					hitval_q  <= val_rd_q;
					hitlink_q <= link_rd_q;
				end else begin
					prev_q <= cur_q;
					cur_q  <= link_rd_q;
				end
			end
			chte_pkg::S_FREE_RD:
				free_rd_q <= free_mem[EW'(CW'(ENTRIES) - live_q - 1'b1)];
			chte_pkg::S_UPDATE: begin
				if (is_ins) begin
					if (hit_q) begin
						val_mem[hitidx_q] <= vin_q;
					end else if (!full_now) begin
						key_mem[fresh_q]  <= key_q;
						val_mem[fresh_q]  <= vin_q;
						link_mem[fresh_q] <= head_rd_q;
						head_mem[bkt_q]   <= {1'b0, fresh_q};
					end
				end else if (is_era && hit_q) begin
					if (prev_q < NULLP) link_mem[prev_q[EW-1:0]] <= hitlink_q;
					else head_mem[bkt_q] <= hitlink_q;
					if (live_q != '0) free_mem[EW'(CW'(ENTRIES) - live_q)] <= hitidx_q;
				end
				found       <= hit_q;
				value_out   <= (!is_ins && !is_era && hit_q) ? hitval_q : 64'd0;
				status      <= (is_ins) ? ((!hit_q && full_now) ? chte_pkg::ST_FULL
					: chte_pkg::ST_OK) : (hit_q ? chte_pkg::ST_OK : chte_pkg::ST_NOTFOUND);
			end
			default: ;
		endcase
	end

	// The free stack starts with slot i holding ENTRIES-1-i. A slot at or above
	// the lowest stack depth reached so far has been rewritten by a push before
	// it can be popped again; below that mark the starting value still stands.
	logic [CW-1:0] low_q;
	logic [EW-1:0] free_sel;
	assign free_sel = EW'(CW'(ENTRIES) - live_q - 1'b1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) low_q <= CW'(ENTRIES);
		else if (state_q == chte_pkg::S_UPDATE && is_ins && !hit_q && !full_now
			&& CW'(free_sel) < low_q)
			low_q <= CW'(free_sel);
	end
	logic [EW-1:0] fresh_pick;
	assign fresh_pick = (CW'(free_sel) >= low_q) ? free_rd_q : EW'(ENTRIES - 1) - free_sel;

	always_ff @(posedge clk) begin
		if (state_q == chte_pkg::S_FREE_WAIT) fresh_q <= fresh_pick;
	end

	assign entry_count = 9'(live_q);
endmodule
